// ===== hdl/sobel_gradient_3x3_core_defines.svh =====
// Assertion macros used by the top level of the Sobel gradient core.
`ifndef SOBEL_GRADIENT_3X3_CORE_DEFINES_SVH
`define SOBEL_GRADIENT_3X3_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sgr_pkg.sv =====
// Types, register indexes and the gradient function of the Sobel gradient core.
package sgr_pkg;

    localparam int FW_BITS  = 12;
    localparam int FH_BITS  = 13;
    localparam int CFG_DW   = 13;
    localparam int CFG_AW   = 2;
    localparam int PIX_W    = 8;
    localparam int GRAD_W   = 11;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DIRECTION    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_ABSOLUTE     = 2'd3;

    localparam logic [FW_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [FH_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic direction;
        logic absolute;
    } mode_t;

    typedef struct packed {
        logic             valid;
        logic             is_pixel;
        logic [PIX_W-1:0] pix;
        logic             top_mid;
        logic             emit_a;
        logic             a_left1;
        logic             emit_b;
        logic             frame_end;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic                     row_end;
        logic                     frame_end;
        logic                     run_last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } pair_t;

    function automatic logic signed [GRAD_W-1:0] sobel_grad(
        input col_t l, input col_t c, input col_t r, input logic dir, input logic mag);
        logic [9:0]               pos;
        logic [9:0]               neg;
        logic signed [GRAD_W-1:0] g;
        if (!dir) begin
            pos = {2'b00, r.top} + {1'b0, r.mid, 1'b0} + {2'b00, r.bot};
            neg = {2'b00, l.top} + {1'b0, l.mid, 1'b0} + {2'b00, l.bot};
        end else begin
            pos = {2'b00, l.bot} + {1'b0, c.bot, 1'b0} + {2'b00, r.bot};
            neg = {2'b00, l.top} + {1'b0, c.top, 1'b0} + {2'b00, r.top};
        end
        g = $signed({1'b0, pos}) - $signed({1'b0, neg});
        if (mag && g[GRAD_W-1]) begin
            g = -g;
        end
        return g;
    endfunction

endpackage

// ===== hdl/sobel_gradient_3x3_core.sv =====
// Top level of the streaming 3x3 Sobel gradient core.
//
// Pixels enter in raster order on the s_ channel: s_tdata carries the pixel and
// s_tuser marks a flush transaction. Results leave on the m_ channel. The four
// frame registers are written through the cfg_ port; the user must write them
// only while the core is idle, which the core does not enforce. Each result for
// row r is produced while row r+1 arrives; after the last pixel of a frame, one
// flush transaction per column drains the last row. The gradient stage
// registers each transaction and its line memory reads. The core takes one
// transaction per cycle unless stalled. The transaction at the last column of
// a row yields two results and the first column of the next row yields none,
// so each later row of W transactions yields W results. A stall on m_tready
// fills the two-entry result register and the gradient stage, then drops
// s_tready; nothing is lost. Reset clears the counters and the window and sets
// the register file to its defaults; the line memories are not cleared, as no
// stale entry reaches a result.
`include "sobel_gradient_3x3_core_defines.svh"

module sobel_gradient_3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sgr_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [sgr_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] pixel
    input  logic [0:0]                  s_tuser,   // [0] func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [10:0] gradient, [11] row_end, [12] frame_end
    output logic                        m_tlast    // run_last
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    sgr_pkg::cmd_t  cmd;
    logic [CW-1:0]  cmd_idx;
    sgr_pkg::mode_t mode;
    sgr_pkg::pair_t pair;
    sgr_pkg::res_t  head;
    logic           s1_valid, s2_free, en, fire, take;

    assign en       = !s1_valid || s2_free;
    assign fire     = s1_valid && s2_free;
    assign s_tready = en;
    assign take     = s_tvalid && en;

    sgr_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .take     (take),
        .func     (s_tuser[0]),
        .pixel    (s_tdata),
        .cmd      (cmd),
        .cmd_idx  (cmd_idx),
        .mode     (mode)
    );

    sgr_line_buf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .fire    (fire),
        .cmd     (cmd),
        .cmd_idx (cmd_idx),
        .mode    (mode),
        .s1_valid(s1_valid),
        .pair    (pair)
    );

    sgr_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .pair_in (pair),
        .m_tready(m_tready),
        .m_valid (m_tvalid),
        .head    (head),
        .free    (s2_free)
    );

    assign m_tdata = {3'b000, head.frame_end, head.row_end, head.gradient};
    assign m_tlast = head.run_last;

    `SGR_ASSERT_SAME(a_frame_end_is_row_end, m_tvalid && m_tdata[12], m_tdata[11], "frame end without row end")
    `SGR_ASSERT_SAME(a_first_of_two_not_row_end, m_tvalid && !m_tlast, !m_tdata[11], "first of two results marked row end")
    `SGR_ASSERT_NEXT(a_stalled_stage_holds, s1_valid && !s2_free, s1_valid, "gradient stage dropped a transaction")
    `SGR_ASSERT_SAME(a_no_accept_when_full, s1_valid && !s2_free, !s_tready, "input accepted while gradient stage is blocked")

endmodule

// ===== hdl/sgr_ctrl.sv =====
// Configuration registers and the row, column and flush sequencer of the Sobel core.
module sgr_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sgr_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [sgr_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        take,
    input  logic                        func,
    input  logic [sgr_pkg::PIX_W-1:0]   pixel,
    output sgr_pkg::cmd_t               cmd,
    output logic [CW-1:0]               cmd_idx,
    output sgr_pkg::mode_t              mode
);

    localparam int LW = (CW + 1 > sgr_pkg::FW_BITS) ? CW + 1 : sgr_pkg::FW_BITS;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = (RW + 1 > sgr_pkg::FH_BITS) ? RW + 1 : sgr_pkg::FH_BITS;

    logic [sgr_pkg::FW_BITS-1:0] frame_width_reg;
    logic [sgr_pkg::FH_BITS-1:0] frame_height_reg;
    logic                        direction_reg;
    logic                        absolute_reg;

    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] flush_cnt_reg, flush_cnt_next;
    logic          draining_reg, draining_next;
    logic          single_row_reg, single_row_next;

    logic [LW-1:0] w_eff, w_last;
    logic [HW-1:0] h_eff, h_last;
    logic          col_last, flush_last, row_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sgr_pkg::WIDTH_RESET;
            frame_height_reg <= sgr_pkg::HEIGHT_RESET;
            direction_reg    <= 1'b0;
            absolute_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sgr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[sgr_pkg::FW_BITS-1:0];
                sgr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[sgr_pkg::FH_BITS-1:0];
                sgr_pkg::REG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                sgr_pkg::REG_ABSOLUTE:     absolute_reg     <= cfg_wdata[0];
            endcase
        end
    end

    assign mode.direction = direction_reg;
    assign mode.absolute  = absolute_reg;

    always_comb begin
        w_eff = LW'(frame_width_reg);
        if (w_eff < LW'(2)) begin
            w_eff = LW'(2);
        end else if (w_eff > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end
        w_last = w_eff - LW'(1);
        h_eff  = HW'(frame_height_reg);
        if (h_eff < HW'(1)) begin
            h_eff = HW'(1);
        end else if (h_eff > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end
        h_last = h_eff - HW'(1);
    end

    assign col_last   = LW'(col_cnt_reg) >= w_last;
    assign flush_last = LW'(flush_cnt_reg) >= w_last;
    assign row_last   = HW'(row_cnt_reg) >= h_last;

    always_comb begin
        cmd             = '0;
        cmd.pix         = pixel;
        cmd_idx         = col_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        flush_cnt_next  = flush_cnt_reg;
        draining_next   = draining_reg;
        single_row_next = single_row_reg;
        if (take && func == sgr_pkg::FUNC_PIXEL) begin
            cmd.valid      = 1'b1;
            cmd.is_pixel   = 1'b1;
            cmd.top_mid    = row_cnt_reg == RW'(1);
            cmd.emit_a     = row_cnt_reg != '0 && col_cnt_reg != '0;
            cmd.a_left1    = col_cnt_reg == CW'(1);
            cmd.emit_b     = row_cnt_reg != '0 && col_last;
            draining_next  = 1'b0;
            flush_cnt_next = '0;
            if (col_last) begin
                col_cnt_next = '0;
                if (row_last) begin
                    single_row_next = row_cnt_reg == '0;
                    draining_next   = 1'b1;
                    row_cnt_next    = '0;
                end else begin
                    row_cnt_next = row_cnt_reg + RW'(1);
                end
            end else begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end else if (take && draining_reg) begin
            cmd.valid     = 1'b1;
            cmd_idx       = flush_cnt_reg;
            cmd.top_mid   = single_row_reg;
            cmd.emit_a    = flush_cnt_reg != '0;
            cmd.a_left1   = flush_cnt_reg == CW'(1);
            cmd.emit_b    = flush_last;
            cmd.frame_end = 1'b1;
            if (flush_last) begin
                draining_next  = 1'b0;
                flush_cnt_next = '0;
            end else begin
                flush_cnt_next = flush_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            flush_cnt_reg  <= '0;
            draining_reg   <= 1'b0;
            single_row_reg <= 1'b0;
        end else begin
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            flush_cnt_reg  <= flush_cnt_next;
            draining_reg   <= draining_next;
            single_row_reg <= single_row_next;
        end
    end

endmodule

// ===== hdl/sgr_line_buf.sv =====
// Two line memories, the 3x3 window and the gradient stage of the Sobel core.
module sgr_line_buf #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           fire,
    input  sgr_pkg::cmd_t  cmd,
    input  logic [CW-1:0]  cmd_idx,
    input  sgr_pkg::mode_t mode,
    output logic           s1_valid,
    output sgr_pkg::pair_t pair
);

    logic [sgr_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [sgr_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [sgr_pkg::PIX_W-1:0] up_q, mid_q;

    logic          s1_valid_reg;
    sgr_pkg::cmd_t s1_cmd_reg;
    logic [CW-1:0] s1_idx_reg;

    sgr_pkg::col_t window_reg  [3];
    sgr_pkg::col_t window_next [3];
    sgr_pkg::col_t left_a;
    sgr_pkg::res_t res_a, res_b;

    logic rd_en;

    assign rd_en = en && cmd.valid;

    // The middle line is read before it is overwritten at the same address.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mid_q <= middle_mem[cmd_idx];
            if (cmd.is_pixel) begin
                middle_mem[cmd_idx] <= cmd.pix;
            end
        end
    end

    // The write-back address is the previous transaction's column, never the read column.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up_q <= upper_mem[cmd_idx];
        end
        if (fire && s1_cmd_reg.is_pixel) begin
            upper_mem[s1_idx_reg] <= mid_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_cmd_reg <= cmd;
            s1_idx_reg <= cmd_idx;
        end
    end

    assign s1_valid = s1_valid_reg;

    always_comb begin
        window_next[0]     = window_reg[1];
        window_next[1]     = window_reg[2];
        window_next[2].top = s1_cmd_reg.top_mid ? mid_q : up_q;
        window_next[2].mid = mid_q;
        window_next[2].bot = s1_cmd_reg.is_pixel ? s1_cmd_reg.pix : mid_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '{default: '0};
        end else if (fire) begin
            window_reg <= window_next;
        end
    end

    assign left_a = s1_cmd_reg.a_left1 ? window_next[1] : window_next[0];

    always_comb begin
        res_a.gradient  = sgr_pkg::sobel_grad(left_a, window_next[1], window_next[2],
                                              mode.direction, mode.absolute);
        res_a.row_end   = 1'b0;
        res_a.frame_end = 1'b0;
        res_a.run_last  = !s1_cmd_reg.emit_b;
        res_b.gradient  = sgr_pkg::sobel_grad(window_next[1], window_next[2], window_next[2],
                                              mode.direction, mode.absolute);
        res_b.row_end   = 1'b1;
        res_b.frame_end = s1_cmd_reg.frame_end;
        res_b.run_last  = 1'b1;
        pair.count      = {1'b0, s1_cmd_reg.emit_a} + {1'b0, s1_cmd_reg.emit_b};
        pair.r0         = s1_cmd_reg.emit_a ? res_a : res_b;
        pair.r1         = res_b;
    end

endmodule

// ===== hdl/sgr_out_buf.sv =====
// Two-entry result register that feeds the output channel of the Sobel core.
module sgr_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  sgr_pkg::pair_t pair_in,
    input  logic           m_tready,
    output logic           m_valid,
    output sgr_pkg::res_t  head,
    output logic           free
);

    logic [1:0]    cnt_reg, cnt_next;
    logic [1:0]    keep;
    sgr_pkg::res_t r0_reg, r0_next;
    sgr_pkg::res_t r1_reg, r1_next;
    logic          pop;

    assign m_valid = cnt_reg != 2'd0;
    assign pop     = m_valid && m_tready;
    assign keep    = cnt_reg - {1'b0, pop};
    assign free    = ({1'b0, keep} + {1'b0, pair_in.count}) <= 3'd2;
    assign head    = r0_reg;

    always_comb begin
        priority if (fire) begin
            cnt_next = keep + pair_in.count;
        end else begin
            cnt_next = keep;
        end
    end

    always_comb begin
        r0_next = pop ? r1_reg : r0_reg;
        r1_next = r1_reg;
        if (fire) begin
            priority if (keep == 2'd0) begin
                r0_next = pair_in.r0;
                r1_next = pair_in.r1;
            end else if (keep == 2'd1) begin
                r1_next = pair_in.r0;
            end else begin
                r1_next = r1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

// ===== sim/sobel_gradient_checker.sv =====
// Monitor that predicts the Sobel gradient results from the input stream and compares them.
module sobel_gradient_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sgr_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [sgr_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] pixel
    input  logic [0:0]                  s_tuser,   // [0] func
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // [10:0] gradient, [11] row_end, [12] frame_end
    input  logic                        m_tlast,   // run_last
    output int                          fail_count,
    output int                          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import sgr_pkg::*;

    localparam int LINE_DEPTH = 2048;
    localparam int ROW_LIMIT  = 4096;

    logic [PIX_W-1:0]   two_rows_up [LINE_DEPTH];
    logic [PIX_W-1:0]   one_row_up [LINE_DEPTH];
    logic [PIX_W-1:0]   win [3][3];
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        drain_pos;
    bit                 in_drain;
    bit                 one_row_frame;
    logic [FW_BITS-1:0] width_reg;
    logic [FH_BITS-1:0] height_reg;
    logic               dir_reg;
    logic               mag_reg;
    res_t               gradient_q [$];

    initial begin
        fail_count = 0;
        pending_results = 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            two_rows_up[i] = '0;
            one_row_up[i]  = '0;
        end
    end

    function automatic int weighted(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
        return int'(a) + 2 * int'(b) + int'(c);
    endfunction

    function automatic logic signed [GRAD_W-1:0] response(input int l, input int m, input int r);
        int g;
        if (!dir_reg) begin
            g = weighted(win[r][0], win[r][1], win[r][2]) - weighted(win[l][0], win[l][1], win[l][2]);
        end else begin
            g = weighted(win[l][2], win[m][2], win[r][2]) - weighted(win[l][0], win[m][0], win[r][0]);
        end
        if (mag_reg && g < 0) begin
            g = -g;
        end
        return g[GRAD_W-1:0];
    endfunction

    task automatic shift_column(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
                                input logic [PIX_W-1:0] bot);
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
                win[k][j] = win[k+1][j];
            end
        end
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = bot;
    endtask

    task automatic queue_column(input int unsigned col, input bit at_last, input bit final_row);
        res_t res;
        if (col >= 1) begin
            res.gradient  = response(col >= 2 ? 0 : 1, 1, 2);
            res.row_end   = 1'b0;
            res.frame_end = 1'b0;
            res.run_last  = !at_last;
            gradient_q.push_back(res);
        end
        if (at_last) begin
            res.gradient  = response(1, 2, 2);
            res.row_end   = 1'b1;
            res.frame_end = final_row;
            res.run_last  = 1'b1;
            gradient_q.push_back(res);
        end
    endtask

    task automatic predict_gradients(input logic func, input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      idx;
        bit               at_last;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] center;
        w = width_reg < 2 ? 2 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
        h = height_reg < 1 ? 1 : (height_reg > ROW_LIMIT ? ROW_LIMIT : height_reg);
        if (func == FUNC_PIXEL) begin
            c = col_pos;
            idx = c < LINE_DEPTH ? c : LINE_DEPTH - 1;
            at_last = c >= w - 1;
            in_drain = 1'b0;
            drain_pos = 0;
            above = two_rows_up[idx];
            center = one_row_up[idx];
            shift_column(row_pos == 1 ? center : above, center, pix);
            two_rows_up[idx] = center;
            one_row_up[idx] = pix;
            if (row_pos >= 1) begin
                queue_column(c, at_last, 1'b0);
            end
            if (at_last) begin
                col_pos = 0;
                if (row_pos >= h - 1) begin
                    one_row_frame = row_pos == 0;
                    in_drain = 1'b1;
                    drain_pos = 0;
                    row_pos = 0;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        end else if (in_drain) begin
            c = drain_pos;
            idx = c < LINE_DEPTH ? c : LINE_DEPTH - 1;
            at_last = c >= w - 1;
            center = one_row_up[idx];
            shift_column(one_row_frame ? center : two_rows_up[idx], center, center);
            queue_column(c, at_last, 1'b1);
            if (at_last) begin
                in_drain = 1'b0;
                drain_pos = 0;
            end else begin
                drain_pos++;
            end
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win[k][j] = '0;
                end
            end
            col_pos = 0;
            row_pos = 0;
            drain_pos = 0;
            in_drain = 1'b0;
            one_row_frame = 1'b0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            dir_reg = 1'b0;
            mag_reg = 1'b0;
            gradient_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH: width_reg = cfg_wdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata[FH_BITS-1:0];
                    REG_DIRECTION: dir_reg = cfg_wdata[0];
                    REG_ABSOLUTE: mag_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_gradients(s_tuser[0], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (gradient_q.size() == 0) begin
                    $error("Unexpected result with gradient %0d while no result is pending.",
                           $signed(m_tdata[GRAD_W-1:0]));
                    fail_count++;
                end else begin
                    want = gradient_q.pop_front();
                    if (m_tdata[GRAD_W-1:0] !== want.gradient) begin
                        $error("Field gradient: expected %0d, got %0d.", want.gradient,
                               $signed(m_tdata[GRAD_W-1:0]));
                        fail_count++;
                    end
                    if (m_tdata[GRAD_W] !== want.row_end) begin
                        $error("Field row_end: expected %0b, got %0b.", want.row_end,
                               m_tdata[GRAD_W]);
                        fail_count++;
                    end
                    if (m_tdata[GRAD_W+1] !== want.frame_end) begin
                        $error("Field frame_end: expected %0b, got %0b.", want.frame_end,
                               m_tdata[GRAD_W+1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $error("Field run_last: expected %0b, got %0b.", want.run_last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending_results <= gradient_q.size();
    end

endmodule

// ===== sim/tb_sobel_gradient_3x3_core.sv =====
// Top-level testbench that drives frames of pixels into the Sobel gradient core.
module tb_sobel_gradient_3x3_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sgr_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_STALL   = 300;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending_results;
    int                   send_idle_pct = 17;
    int                   recv_idle_pct = 45;
    bit                   stall_req = 1'b0;
    int                   cycle_count = 0;

    sobel_gradient_3x3_core #(
        .MAX_WIDTH  (2048),
        .MAX_HEIGHT (4096)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sobel_gradient_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic func, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_pixels(input int unsigned count);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(7);
            send_item(FUNC_PIXEL, roll == 0 ? 8'd0 : (roll == 1 ? 8'd255 : 8'($urandom_range(255))));
        end
    endtask

    task automatic send_flushes(input int unsigned count);
        repeat (count) send_item(FUNC_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int unsigned width, input int unsigned height,
                             input bit dir, input bit mag);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_wdata <= CFG_DW'(width);
        @(posedge aclk);
        cfg_addr <= REG_FRAME_HEIGHT;
        cfg_wdata <= CFG_DW'(height);
        @(posedge aclk);
        cfg_addr <= REG_DIRECTION;
        cfg_wdata <= CFG_DW'(dir);
        @(posedge aclk);
        cfg_addr <= REG_ABSOLUTE;
        cfg_wdata <= CFG_DW'(mag);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned roll;
        int unsigned nflush;
        int          random_items;
        bit          drain_open;
        bit          long_stall_done;
        random_items = 0;
        drain_open = 1'b0;
        long_stall_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_flushes(3);

        configure(4, 3, 1'b0, 1'b0);
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 4; c++) begin
                send_item(FUNC_PIXEL, c >= 2 ? 8'd255 : 8'd0);
            end
        end
        configure(4, 3, 1'b1, 1'b1);
        for (int c = 0; c < 4; c++) begin
            send_item(FUNC_PIXEL, c >= 2 ? 8'd0 : 8'd255);
        end
        send_flushes(4);

        configure(3, 2, 1'b1, 1'b0);
        repeat (3) send_item(FUNC_PIXEL, 8'd255);
        repeat (3) send_item(FUNC_PIXEL, 8'd0);
        send_flushes(3);

        configure(0, 0, 1'b0, 1'b1);
        send_pixels(2);
        send_flushes(3);

        configure(8, 6, 1'b0, 1'b1);
        send_pixels(13);
        configure(3, 6, 1'b0, 1'b1);
        send_pixels(3);
        configure(3, 2, 1'b0, 1'b1);
        send_pixels(1);
        send_flushes(5);

        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 45;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                w = $urandom_range(8, 2);
            end else if (roll < 95) begin
                w = $urandom_range(32, 9);
            end else begin
                w = $urandom_range(100, 33);
            end
            h = ($urandom_range(99) < 80) ? $urandom_range(5, 1) : $urandom_range(10, 6);
            if (send_idle_pct == 0 && !long_stall_done) begin
                w = 16;
                h = 4;
            end
            configure(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)));
            if (send_idle_pct == 0 && !long_stall_done) begin
                long_stall_done = 1'b1;
                stall_req = 1'b1;
            end
            if (!drain_open && $urandom_range(9) == 0) begin
                send_flushes($urandom_range(3, 1));
            end
            send_pixels(w * h);
            roll = $urandom_range(9);
            if (roll == 0) begin
                nflush = $urandom_range(w - 1);
                drain_open = 1'b1;
            end else if (roll == 1) begin
                nflush = w + $urandom_range(3, 1);
                drain_open = 1'b0;
            end else begin
                nflush = w;
                drain_open = 1'b0;
            end
            send_flushes(nflush);
            random_items += w * h + (nflush < w ? nflush : w);
        end

        settle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sgr_pkg.sv
hdl/sgr_ctrl.sv
hdl/sgr_line_buf.sv
hdl/sgr_out_buf.sv
hdl/sobel_gradient_3x3_core.sv
sim/sobel_gradient_checker.sv
sim/tb_sobel_gradient_3x3_core.sv
